// ----- rtl/core/wtsp_pkg.sv -----
`default_nettype none
package wtsp_pkg;

  // Fixed-point format of coordinates, coefficients and results.
  localparam int FRAC_BITS = 16;
  localparam int CRD_W     = 32;
  localparam int SC_W      = 16;

  // Clip coordinate width: a floored product keeps 64 - FRAC_BITS bits, plus growth.
  localparam int DOT_W  = 66 - FRAC_BITS;
  localparam int PR_W   = DOT_W + SC_W;
  localparam int DEN_W  = DOT_W + 1;
  localparam int NUM_W  = PR_W + FRAC_BITS;
  // Quotient bits kept. Larger quotients saturate the pixel result anyway.
  localparam int Q_W    = FRAC_BITS + 25;
  localparam int TOP_W  = NUM_W - Q_W;
  localparam int TERM_W = Q_W + 2;
  localparam int SUM_W  = Q_W + 3;

  localparam longint W_MIN_VAL = ((longint'(1) << FRAC_BITS) + 50) / 100;
  localparam longint HALF_VAL  = longint'(1) << (FRAC_BITS - 1);

  // Configuration register indexes.
  localparam logic [2:0] REG_ROW0_XY  = 3'd0;
  localparam logic [2:0] REG_ROW0_ZW  = 3'd1;
  localparam logic [2:0] REG_ROW1_XY  = 3'd2;
  localparam logic [2:0] REG_ROW1_ZW  = 3'd3;
  localparam logic [2:0] REG_ROW3_XY  = 3'd4;
  localparam logic [2:0] REG_ROW3_ZW  = 3'd5;
  localparam logic [2:0] REG_SCR_SIZE = 3'd6;
  localparam logic [2:0] REG_WIN_ORG  = 3'd7;

  // Decoded configuration: coef[row][col], rows are clip x, y and w.
  typedef struct packed {
    logic [2:0][3:0][31:0] coef;
    logic [15:0]           width;
    logic [15:0]           height;
    logic signed [15:0]    left;
    logic signed [15:0]    top;
  } cfg_t;

  // Per-item flags that travel beside the divider data.
  typedef struct packed {
    logic vis;
    logic neg_x;
    logic neg_y;
  } side_t;

endpackage
`default_nettype wire

// ----- rtl/core/wtsp_cfg_regs.sv -----
`default_nettype none
module wtsp_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire logic [2:0]    wr_index,
  input  wire logic [63:0]   wr_data,
  output wtsp_pkg::cfg_t     cfg
);

  logic [63:0] row_r [6];
  logic [31:0] size_r;
  logic [31:0] org_r;

  // Register file with write decode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= 64'h0001_0000_0000_0000;
      row_r[1] <= 64'd0;
      row_r[2] <= 64'h0000_0000_0001_0000;
      row_r[3] <= 64'd0;
      row_r[4] <= 64'd0;
      row_r[5] <= 64'h0000_0000_0001_0000;
      size_r   <= 32'd125830200;
      org_r    <= 32'd0;
    end else if (wr_en) begin
      unique case (wr_index)
        wtsp_pkg::REG_ROW0_XY:  row_r[0] <= wr_data;
        wtsp_pkg::REG_ROW0_ZW:  row_r[1] <= wr_data;
        wtsp_pkg::REG_ROW1_XY:  row_r[2] <= wr_data;
        wtsp_pkg::REG_ROW1_ZW:  row_r[3] <= wr_data;
        wtsp_pkg::REG_ROW3_XY:  row_r[4] <= wr_data;
        wtsp_pkg::REG_ROW3_ZW:  row_r[5] <= wr_data;
        wtsp_pkg::REG_SCR_SIZE: size_r   <= wr_data[31:0];
        wtsp_pkg::REG_WIN_ORG:  org_r    <= wr_data[31:0];
        default: ;
      endcase
    end
  end

  // Split the packed registers into coefficients and viewport fields.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      cfg.coef[r][0] = row_r[2*r][63:32];
      cfg.coef[r][1] = row_r[2*r][31:0];
      cfg.coef[r][2] = row_r[2*r+1][63:32];
      cfg.coef[r][3] = row_r[2*r+1][31:0];
    end
    cfg.width  = size_r[31:16];
    cfg.height = size_r[15:0];
    cfg.left   = $signed(org_r[31:16]);
    cfg.top    = $signed(org_r[15:0]);
  end

endmodule
`default_nettype wire

// ----- rtl/core/wtsp_transform.sv -----
`default_nettype none
module wtsp_transform (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             ce,
  input  wire logic                             in_valid,
  input  wire logic signed [31:0]               px,
  input  wire logic signed [31:0]               py,
  input  wire logic signed [31:0]               pz,
  input  wtsp_pkg::cfg_t                        cfg,
  output logic                                  out_valid,
  output logic signed [wtsp_pkg::DOT_W-1:0]     clip [3]
);

  logic signed [63:0] prod_r [3][3];
  logic signed [31:0] trans_r [3];
  logic               v1_r;
  logic signed [wtsp_pkg::DOT_W-1:0] clip_r [3];
  logic               v2_r;

  // Stage 1: nine full-precision products.
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int r = 0; r < 3; r++) begin
        prod_r[r][0] <= $signed(cfg.coef[r][0]) * px;
        prod_r[r][1] <= $signed(cfg.coef[r][1]) * py;
        prod_r[r][2] <= $signed(cfg.coef[r][2]) * pz;
        trans_r[r]   <= $signed(cfg.coef[r][3]);
      end
    end
  end

  // Stage 2: floor each product to the fixed-point grid and sum the row.
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int r = 0; r < 3; r++) begin
        clip_r[r] <= wtsp_pkg::DOT_W'(prod_r[r][0] >>> wtsp_pkg::FRAC_BITS)
                   + wtsp_pkg::DOT_W'(prod_r[r][1] >>> wtsp_pkg::FRAC_BITS)
                   + wtsp_pkg::DOT_W'(prod_r[r][2] >>> wtsp_pkg::FRAC_BITS)
                   + wtsp_pkg::DOT_W'(trans_r[r]);
      end
    end
  end

  // Valid bits for both stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (ce) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  assign out_valid = v2_r;
  assign clip      = clip_r;

endmodule
`default_nettype wire

// ----- rtl/core/wtsp_div_pipe.sv -----
`default_nettype none
module wtsp_div_pipe (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          ce,
  input  wire logic                          in_valid,
  input  wtsp_pkg::side_t                    in_side,
  input  wire logic [wtsp_pkg::PR_W-1:0]     prod_x,
  input  wire logic [wtsp_pkg::PR_W-1:0]     prod_y,
  input  wire logic [wtsp_pkg::DEN_W-1:0]    den,
  output logic                               out_valid,
  output wtsp_pkg::side_t                    out_side,
  output logic [wtsp_pkg::Q_W-1:0]           quo_x,
  output logic [wtsp_pkg::Q_W-1:0]           quo_y,
  output logic                               rem_nz_x,
  output logic                               rem_nz_y,
  output logic                               over_x,
  output logic                               over_y
);

  localparam int QW = wtsp_pkg::Q_W;
  localparam int DW = wtsp_pkg::DEN_W;

  logic [DW-1:0]   rx_r   [QW+1];
  logic [DW-1:0]   ry_r   [QW+1];
  logic [QW-1:0]   lx_r   [QW+1];
  logic [QW-1:0]   ly_r   [QW+1];
  logic [QW-1:0]   qx_r   [QW+1];
  logic [QW-1:0]   qy_r   [QW+1];
  logic [DW-1:0]   d_r    [QW+1];
  logic            ox_r   [QW+1];
  logic            oy_r   [QW+1];
  wtsp_pkg::side_t side_r [QW+1];
  logic            v_r    [QW+1];

  logic [wtsp_pkg::NUM_W-1:0] num_x, num_y;
  logic [DW-1:0]              top_x, top_y;
  logic                       ovf_x, ovf_y;

  // Numerators carry the fraction shift; the upper part seeds the remainder.
  always_comb begin
    num_x = {prod_x, {wtsp_pkg::FRAC_BITS{1'b0}}};
    num_y = {prod_y, {wtsp_pkg::FRAC_BITS{1'b0}}};
    top_x = DW'(num_x[wtsp_pkg::NUM_W-1:QW]);
    top_y = DW'(num_y[wtsp_pkg::NUM_W-1:QW]);
    ovf_x = top_x >= den;
    ovf_y = top_y >= den;
  end

  // Entry stage: overflow check and remainder seed.
  always_ff @(posedge clk) begin
    if (ce) begin
      rx_r[0]   <= ovf_x ? '0 : top_x;
      ry_r[0]   <= ovf_y ? '0 : top_y;
      lx_r[0]   <= num_x[QW-1:0];
      ly_r[0]   <= num_y[QW-1:0];
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
      d_r[0]    <= den;
      ox_r[0]   <= ovf_x;
      oy_r[0]   <= ovf_y;
      side_r[0] <= in_side;
    end
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [DW:0] tx, ty;
    logic        gx, gy;

    always_comb begin
      tx = {rx_r[k-1], lx_r[k-1][QW-1]};
      ty = {ry_r[k-1], ly_r[k-1][QW-1]};
      gx = tx >= {1'b0, d_r[k-1]};
      gy = ty >= {1'b0, d_r[k-1]};
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rx_r[k]   <= gx ? DW'(tx - {1'b0, d_r[k-1]}) : DW'(tx);
        ry_r[k]   <= gy ? DW'(ty - {1'b0, d_r[k-1]}) : DW'(ty);
        lx_r[k]   <= lx_r[k-1] << 1;
        ly_r[k]   <= ly_r[k-1] << 1;
        qx_r[k]   <= {qx_r[k-1][QW-2:0], gx};
        qy_r[k]   <= {qy_r[k-1][QW-2:0], gy};
        d_r[k]    <= d_r[k-1];
        ox_r[k]   <= ox_r[k-1];
        oy_r[k]   <= oy_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Valid bits travel with the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QW; k++) v_r[k] <= 1'b0;
    end else if (ce) begin
      v_r[0] <= in_valid;
      for (int k = 1; k <= QW; k++) v_r[k] <= v_r[k-1];
    end
  end

  assign out_valid = v_r[QW];
  assign out_side  = side_r[QW];
  assign quo_x     = qx_r[QW];
  assign quo_y     = qy_r[QW];
  assign rem_nz_x  = rx_r[QW] != '0;
  assign rem_nz_y  = ry_r[QW] != '0;
  assign over_x    = ox_r[QW];
  assign over_y    = oy_r[QW];

endmodule
`default_nettype wire

// ----- rtl/core/world_to_screen_projection_core.sv -----
`default_nettype none
// Projects one world point per cycle to screen pixels while the output is not
// stalled. Each transaction on the input stream is a point (x, y, z in Q16.16);
// each transaction on the output stream is its screen position in Q16.16 pixels
// with a visible flag in tuser. Points are fully independent, so one enters in
// every such cycle and results leave in order; the pipeline holds a restoring
// divider that takes one quotient bit per stage. Matrix coefficients are Q16.16.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Configuration writes are accepted in any cycle and must be made while no
// point is in flight.
module world_to_screen_projection_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream. tdata: world_x [31:0], world_y [63:32], world_z [95:64].
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,
  // Output stream. tdata: screen_x [31:0], screen_y [63:32]. tuser: visible [0].
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,
  output logic [0:0]       out_tuser,
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int DW  = wtsp_pkg::DOT_W;
  localparam int QW  = wtsp_pkg::Q_W;
  localparam int TW  = wtsp_pkg::TERM_W;
  localparam int SW  = wtsp_pkg::SUM_W;
  localparam int FB  = wtsp_pkg::FRAC_BITS;
  localparam logic signed [DW-1:0] W_MIN   = DW'(wtsp_pkg::W_MIN_VAL);
  localparam logic [QW:0]          CAP     = (QW+1)'(1) << QW;
  localparam logic signed [SW-1:0] SAT_MAX = SW'(32'sh7fff_ffff);
  localparam logic signed [SW-1:0] SAT_MIN = SW'(-32'sh7fff_ffff - 1);

  wtsp_pkg::cfg_t  cfg;
  logic            ce;
  logic            v2;
  logic signed [DW-1:0] clip [3];

  logic            v3_r, v4_r, va_r, out_valid_r;
  wtsp_pkg::side_t side3_r, side4_r;
  logic [DW-1:0]   magx3_r, magy3_r;
  logic [DW:0]     den3_r, den4_r;
  logic [wtsp_pkg::PR_W-1:0] prodx4_r, prody4_r;

  logic            vd;
  wtsp_pkg::side_t sided;
  logic [QW-1:0]   qx, qy;
  logic            rnzx, rnzy, ovx, ovy;

  logic            visa_r;
  logic signed [TW-1:0] termx_a_r, termy_a_r;
  logic [QW:0]     magx_d, magy_d;

  logic signed [SW-1:0] base_x, base_y, sum_x, sum_y;
  logic [31:0]     scrx_r, scry_r;
  logic            vis_r;

  // The pipeline advances whenever the output register can take a result.
  assign ce        = !out_valid_r || out_tready;
  assign in_tready = ce;
  assign cfg_ready = 1'b1;

  wtsp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  wtsp_transform u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (in_tvalid),
    .px        ($signed(in_tdata[31:0])),
    .py        ($signed(in_tdata[63:32])),
    .pz        ($signed(in_tdata[95:64])),
    .cfg       (cfg),
    .out_valid (v2),
    .clip      (clip)
  );

  // Stage 3: visibility test, magnitudes and the divisor 2w.
  always_ff @(posedge clk) begin
    if (ce) begin
      side3_r.vis   <= clip[2] >= W_MIN;
      side3_r.neg_x <= clip[0][DW-1];
      side3_r.neg_y <= clip[1][DW-1];
      magx3_r       <= clip[0][DW-1] ? DW'(-clip[0]) : DW'(clip[0]);
      magy3_r       <= clip[1][DW-1] ? DW'(-clip[1]) : DW'(clip[1]);
      den3_r        <= {clip[2], 1'b0};
    end
  end

  // Stage 4: scale the magnitudes by the viewport size.
  always_ff @(posedge clk) begin
    if (ce) begin
      side4_r  <= side3_r;
      prodx4_r <= magx3_r * cfg.width;
      prody4_r <= magy3_r * cfg.height;
      den4_r   <= den3_r;
    end
  end

  wtsp_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (v4_r),
    .in_side   (side4_r),
    .prod_x    (prodx4_r),
    .prod_y    (prody4_r),
    .den       (den4_r),
    .out_valid (vd),
    .out_side  (sided),
    .quo_x     (qx),
    .quo_y     (qy),
    .rem_nz_x  (rnzx),
    .rem_nz_y  (rnzy),
    .over_x    (ovx),
    .over_y    (ovy)
  );

  // Stage A: floor toward minus infinity, clamp and apply the sign.
  always_comb begin
    magx_d = ovx ? CAP : (QW+1)'(qx) + (QW+1)'(sided.neg_x && rnzx);
    magy_d = ovy ? CAP : (QW+1)'(qy) + (QW+1)'(sided.neg_y && rnzy);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      visa_r    <= sided.vis;
      termx_a_r <= sided.neg_x ? -TW'(magx_d) : TW'(magx_d);
      termy_a_r <= sided.neg_y ? -TW'(magy_d) : TW'(magy_d);
    end
  end

  // Pixel offsets: half the viewport, rounding half and window origin.
  always_comb begin
    base_x = (SW'($signed({1'b0, cfg.width[15:1]})) <<< FB) + SW'(wtsp_pkg::HALF_VAL)
           + (SW'(cfg.left) <<< FB);
    base_y = (SW'($signed({1'b0, cfg.height[15:1]})) <<< FB) - SW'(wtsp_pkg::HALF_VAL)
           + (SW'(cfg.top) <<< FB);
    sum_x  = base_x + SW'(termx_a_r);
    sum_y  = base_y - SW'(termy_a_r);
  end

  // Stage B: saturate into the output register, or zero both coordinates of a point that is not visible.
  always_ff @(posedge clk) begin
    if (ce) begin
      vis_r <= visa_r;
      if (!visa_r) begin
        scrx_r <= '0;
        scry_r <= '0;
      end else begin
        scrx_r <= (sum_x > SAT_MAX) ? SAT_MAX[31:0] :
                  (sum_x < SAT_MIN) ? SAT_MIN[31:0] : sum_x[31:0];
        scry_r <= (sum_y > SAT_MAX) ? SAT_MAX[31:0] :
                  (sum_y < SAT_MIN) ? SAT_MIN[31:0] : sum_y[31:0];
      end
    end
  end

  // Valid bits of the stages owned here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      va_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (ce) begin
      v3_r        <= v2;
      v4_r        <= v3_r;
      va_r        <= vd;
      out_valid_r <= va_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {scry_r, scrx_r};
  assign out_tuser  = vis_r;

  // A point that is not visible reports both coordinates as zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 64'd0)
    else $error("invisible point with nonzero coordinates");

  // No input is taken while a result waits.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted during output stall");

  // A stall freezes the pipeline contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    !ce |=> $stable(va_r) && $stable(termx_a_r))
    else $error("pipeline moved during stall");

endmodule
`default_nettype wire
